>>> hdl/amd_pkg.sv
package amd_pkg;

  // frame geometry
  localparam int FrameLen = 9;
  localparam logic [3:0] FRAME_LEN = 4'd9;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  // control characters
  localparam logic [7:0] CH_CLEAR = 8'h61;
  localparam logic [7:0] CH_END   = 8'h62;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  // opcodes after subtracting ascii zero
  localparam logic signed [8:0] OP_MOVE   = 9'sd1;
  localparam logic signed [8:0] OP_LEFT_A = 9'sd2;
  localparam logic signed [8:0] OP_LEFT_B = 9'sd3;
  localparam logic signed [8:0] OP_RIGHT  = 9'sd4;
  localparam logic signed [8:0] OP_WHEEL  = 9'sd5;

  // action codes
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_MOVE  = 3'd1;
  localparam logic [2:0] ACT_LEFT  = 3'd2;
  localparam logic [2:0] ACT_RIGHT = 3'd3;
  localparam logic [2:0] ACT_WHEEL = 3'd4;

  typedef logic [FrameLen-1:0][7:0] frame_t;

  // frame push from front to queue
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } push_t;

  // decoded command between back stages
  typedef struct packed {
    logic signed [8:0]  op_code;
    logic [2:0]         action;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic               neg_x;
    logic               neg_y;
    logic               mul3;
  } cmd_t;

  // byte minus ascii zero, range -48..207
  function automatic logic signed [8:0] digit(input logic [7:0] b);
    digit = $signed({1'b0, b}) - $signed({1'b0, CH_ZERO});
  endfunction

  // three decimal digits, range -5328..22977
  function automatic logic signed [15:0] three_digits(input logic [7:0] h,
                                                      input logic [7:0] t,
                                                      input logic [7:0] u);
    logic signed [15:0] dh;
    logic signed [15:0] dt;
    logic signed [15:0] du;
    dh = 16'(digit(h));
    dt = 16'(digit(t));
    du = 16'(digit(u));
    three_digits = (dh <<< 6) + (dh <<< 5) + (dh <<< 2)
                 + (dt <<< 3) + (dt <<< 1) + du;
  endfunction

endpackage

>>> hdl/amd_if.sv
interface amd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface amd_out_if;
  logic               valid;
  logic               ready;
  logic signed [8:0]  op_code;
  logic [2:0]         action;
  logic signed [17:0] delta_x;
  logic signed [17:0] delta_y;

  modport source (output valid, output op_code, output action, output delta_x,
                  output delta_y, input ready);
  modport sink (input valid, input op_code, input action, input delta_x,
                input delta_y, output ready);
endinterface

>>> hdl/amd_front.sv
module amd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  output logic              in_ready,
  input  logic              q_full,
  output amd_pkg::push_t    push
);

  logic [3:0]      count_r;
  logic [3:0]      count_nxt;
  amd_pkg::frame_t store_r;
  logic            take;
  logic            is_end;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign is_end   = (in_byte == amd_pkg::CH_END) && (count_r == amd_pkg::FRAME_LEN);

  // frame end pushes a snapshot of the store
  assign push.valid = take && is_end;
  assign push.frame = store_r;

  // fill count update
  always_comb begin
    count_nxt = count_r;
    if (take) begin
      if (in_byte == amd_pkg::CH_CLEAR) begin
        count_nxt = 4'd0;
      end else if (!is_end && count_r < amd_pkg::COUNT_MAX) begin
        count_nxt = count_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // store byte at the count position, overrun bytes dropped
  always_ff @(posedge clk) begin
    for (int i = 0; i < amd_pkg::FrameLen; i++) begin
      if (take && in_byte != amd_pkg::CH_CLEAR && !is_end && count_r == 4'(i)) begin
        store_r[i] <= in_byte;
      end
    end
  end

endmodule

>>> hdl/amd_queue.sv
module amd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  amd_pkg::push_t     push,
  output logic               full,
  output logic               head_valid,
  output amd_pkg::frame_t    head_frame,
  input  logic               pop
);

  amd_pkg::frame_t mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      level_r;
  logic [1:0]      level_nxt;
  logic            do_pop;

  assign full       = (level_r == 2'd2);
  assign head_valid = (level_r != 2'd0);
  assign head_frame = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // occupancy
  always_comb begin
    level_nxt = level_r;
    if (push.valid && !do_pop) begin
      level_nxt = level_r + 2'd1;
    end else if (!push.valid && do_pop) begin
      level_nxt = level_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      level_r <= level_nxt;
      if (push.valid) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // frame storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.frame;
    end
  end

endmodule

>>> hdl/amd_back.sv
module amd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  amd_pkg::frame_t   head_frame,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [8:0] out_op_code,
  output logic [2:0]        out_action,
  output logic signed [17:0] out_delta_x,
  output logic signed [17:0] out_delta_y
);

  amd_pkg::cmd_t     dec;
  amd_pkg::cmd_t     s1_r;
  logic              s1_valid_r;
  logic              out_valid_r;
  logic              out_load;
  logic              s1_load;
  logic signed [8:0] op;
  logic signed [17:0] ext_x;
  logic signed [17:0] ext_y;
  logic signed [17:0] sx;
  logic signed [17:0] sy;
  logic signed [17:0] dx_nxt;
  logic signed [17:0] dy_nxt;
  logic signed [8:0]  op_r;
  logic [2:0]         act_r;
  logic signed [17:0] dx_r;
  logic signed [17:0] dy_r;

  assign out_load = !out_valid_r || out_ready;
  assign s1_load  = !s1_valid_r || out_load;
  assign pop      = head_valid && s1_load;

  // opcode decode and digit sums
  always_comb begin
    op        = amd_pkg::digit(head_frame[0]);
    dec       = '0;
    dec.op_code = op;
    unique case (op) inside
      amd_pkg::OP_MOVE: begin
        dec.action = amd_pkg::ACT_MOVE;
        dec.mag_x  = amd_pkg::three_digits(head_frame[2], head_frame[3], head_frame[4]);
        dec.mag_y  = amd_pkg::three_digits(head_frame[6], head_frame[7], head_frame[8]);
        dec.neg_x  = (head_frame[1] == amd_pkg::CH_ZERO);
        dec.neg_y  = (head_frame[5] == amd_pkg::CH_ZERO);
        dec.mul3   = 1'b1;
      end
      amd_pkg::OP_LEFT_A, amd_pkg::OP_LEFT_B: begin
        dec.action = amd_pkg::ACT_LEFT;
      end
      amd_pkg::OP_RIGHT: begin
        dec.action = amd_pkg::ACT_RIGHT;
      end
      amd_pkg::OP_WHEEL: begin
        dec.action = amd_pkg::ACT_WHEEL;
        dec.mag_x  = amd_pkg::three_digits(head_frame[2], head_frame[3], head_frame[4]);
        dec.neg_x  = (head_frame[1] == amd_pkg::CH_ONE);
      end
      default: begin
        dec.action = amd_pkg::ACT_NONE;
      end
    endcase
  end

  // scale and sign
  always_comb begin
    ext_x  = {{2{s1_r.mag_x[15]}}, s1_r.mag_x};
    ext_y  = {{2{s1_r.mag_y[15]}}, s1_r.mag_y};
    sx     = s1_r.mul3 ? (ext_x <<< 1) + ext_x : ext_x;
    sy     = s1_r.mul3 ? (ext_y <<< 1) + ext_y : ext_y;
    dx_nxt = s1_r.neg_x ? -sx : sx;
    dy_nxt = s1_r.neg_y ? -sy : sy;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= head_valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_r <= dec;
    end
    if (out_load && s1_valid_r) begin
      op_r  <= s1_r.op_code;
      act_r <= s1_r.action;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_op_code = op_r;
  assign out_action  = act_r;
  assign out_delta_x = dx_r;
  assign out_delta_y = dy_r;

endmodule

>>> hdl/ascii_mouse_command_deframer.sv
// ascii mouse command deframer
// in_if carries one ascii byte per word (rx_byte). the byte 'a' clears the
// frame; any other byte is stored at the fill position. 'b' with exactly
// nine bytes stored ends a frame and issues one command word; a repeated
// 'b' reissues the same frame. bytes past nine are dropped until 'a'.
// out_if carries op_code, action (0 none, 1 move, 2 left, 3 right,
// 4 wheel), delta_x and delta_y; unused deltas are zero.
// throughput: one byte per cycle while the frame queue is not full,
// including back to back frame ends. a command word passes from the
// queue through one decode stage and one output register.
// a two-frame queue sits between the byte front end and the decoder, so
// in_if.ready drops only when that queue is full; a stalled out_if holds
// its word and fills the decode stage and queue before the input stalls.
// reset (rst_n low, synchronous) clears the fill count, the queue and the
// output valid; stored frame bytes are not cleared.
module ascii_mouse_command_deframer (
  input  logic     clk,
  input  logic     rst_n,
  amd_in_if.sink   in_if,
  amd_out_if.source out_if
);

  amd_pkg::push_t  push;
  logic            q_full;
  logic            head_valid;
  amd_pkg::frame_t head_frame;
  logic            pop;

  // byte front end
  amd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_byte  (in_if.rx_byte),
    .in_ready (in_if.ready),
    .q_full   (q_full),
    .push     (push)
  );

  // frame queue
  amd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .head_valid (head_valid),
    .head_frame (head_frame),
    .pop        (pop)
  );

  // command decoder
  amd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_frame  (head_frame),
    .pop         (pop),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_op_code (out_if.op_code),
    .out_action  (out_if.action),
    .out_delta_x (out_if.delta_x),
    .out_delta_y (out_if.delta_y)
  );

endmodule

>>> test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ByteTotal   = 1500;
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 300;
  localparam int HoldAtByte  = 300;
  localparam int CalmFrom    = 700;
  localparam int CalmTo      = 900;
  localparam int DrainCycles = 8;

  // one decoded mouse command as it leaves the block
  typedef struct packed {
    logic signed [8:0]  op_code;
    logic [2:0]         action;
    logic signed [17:0] delta_x;
    logic signed [17:0] delta_y;
  } mouse_cmd_t;

  // tracks the frame buffer and the commands still owed by the block
  class mouse_cmd_board;
    logic [7:0] frame_bytes [amd_pkg::FrameLen];
    logic [3:0] fill;
    mouse_cmd_t cmds_due[$];
    int errors;

    function new();
      fill = 0;
      errors = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    endfunction

    function int ascii_num(int pos);
      return int'(frame_bytes[pos]) - int'(amd_pkg::CH_ZERO);
    endfunction

    function int num3(int pos);
      return ascii_num(pos) * 100 + ascii_num(pos + 1) * 10 + ascii_num(pos + 2);
    endfunction

    // update the frame state for one accepted word, queue a command on frame end
    function void note_byte(logic [7:0] b);
      int op;
      int dx;
      int dy;
      logic [2:0] act;
      mouse_cmd_t cmd;
      if (b == amd_pkg::CH_CLEAR) begin
        fill = 4'd0;
      end else if (b == amd_pkg::CH_END && fill == amd_pkg::FRAME_LEN) begin
        op = ascii_num(0);
        dx = 0;
        dy = 0;
        act = amd_pkg::ACT_NONE;
        case (op)
          amd_pkg::OP_MOVE: begin
            act = amd_pkg::ACT_MOVE;
            dx = 3 * num3(2);
            if (frame_bytes[1] == amd_pkg::CH_ZERO) dx = -dx;
            dy = 3 * num3(6);
            if (frame_bytes[5] == amd_pkg::CH_ZERO) dy = -dy;
          end
          amd_pkg::OP_LEFT_A, amd_pkg::OP_LEFT_B: act = amd_pkg::ACT_LEFT;
          amd_pkg::OP_RIGHT: act = amd_pkg::ACT_RIGHT;
          amd_pkg::OP_WHEEL: begin
            act = amd_pkg::ACT_WHEEL;
            dx = num3(2);
            if (frame_bytes[1] == amd_pkg::CH_ONE) dx = -dx;
          end
          default: ;
        endcase
        cmd.op_code = 9'(op);
        cmd.action  = act;
        cmd.delta_x = 18'(dx);
        cmd.delta_y = 18'(dy);
        cmds_due.push_back(cmd);
      end else begin
        // bytes past the frame length are dropped, count saturates
        if (fill < amd_pkg::FRAME_LEN) frame_bytes[fill] = b;
        if (fill < amd_pkg::COUNT_MAX) fill = fill + 4'd1;
      end
    endfunction

    // compare one command word against the oldest one owed
    function void check_word(mouse_cmd_t got);
      mouse_cmd_t want;
      if (cmds_due.size() == 0) begin
        $display("%0t: unexpected command word op_code %0d action %0d dx %0d dy %0d",
                 $time, got.op_code, got.action, got.delta_x, got.delta_y);
        errors++;
        return;
      end
      want = cmds_due.pop_front();
      if (got.op_code !== want.op_code) begin
        $display("%0t: op_code expected %0d got %0d", $time, want.op_code, got.op_code);
        errors++;
      end
      if (got.action !== want.action) begin
        $display("%0t: action expected %0d got %0d", $time, want.action, got.action);
        errors++;
      end
      if (got.delta_x !== want.delta_x) begin
        $display("%0t: delta_x expected %0d got %0d", $time, want.delta_x, got.delta_x);
        errors++;
      end
      if (got.delta_y !== want.delta_y) begin
        $display("%0t: delta_y expected %0d got %0d", $time, want.delta_y, got.delta_y);
        errors++;
      end
    endfunction

    function int left();
      return cmds_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   sent;
  logic calm;

  amd_in_if  in_if ();
  amd_out_if out_if ();

  mouse_cmd_board board = new();

  ascii_mouse_command_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // stretch with no idling on either side
  assign calm = (sent >= CalmFrom) && (sent < CalmTo);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one word, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 14) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_byte(b);
    sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // one random frame: mostly well formed, some noise and broken frames
  task automatic send_frame();
    logic [7:0] bytes_q[$];
    logic [7:0] b;
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 80) begin
      if ($urandom_range(9) != 0) bytes_q.push_back(amd_pkg::CH_CLEAR);
      for (int i = 0; i < amd_pkg::FrameLen; i++) begin
        n = $urandom_range(99);
        if (i == 0) begin
          if (n < 70) b = amd_pkg::CH_ZERO + 8'($urandom_range(6));
          else if (n < 80) b = (n < 75) ? 8'h00 : 8'hff;
          else b = 8'($urandom_range(255));
        end else if (i == 1 || i == 5) begin
          if (n < 45) b = amd_pkg::CH_ZERO;
          else if (n < 90) b = amd_pkg::CH_ONE;
          else b = 8'($urandom_range(255));
        end else begin
          if (n < 85) b = amd_pkg::CH_ZERO + 8'($urandom_range(9));
          else b = 8'($urandom_range(255));
        end
        bytes_q.push_back(b);
      end
      bytes_q.push_back(amd_pkg::CH_END);
      // repeated frame ends reissue the command
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) bytes_q.push_back(amd_pkg::CH_END);
      end
    end else if (pick < 90) begin
      n = $urandom_range(1, 12);
      repeat (n) bytes_q.push_back(8'($urandom_range(255)));
    end else begin
      // wrong length, short or overrun, then an end byte
      bytes_q.push_back(amd_pkg::CH_CLEAR);
      n = $urandom_range(0, 14);
      if (n == amd_pkg::FrameLen) n = amd_pkg::FrameLen + 1;
      repeat (n) bytes_q.push_back(8'($urandom_range(255)));
      bytes_q.push_back(amd_pkg::CH_END);
    end
    send_seq(bytes_q);
  endtask

  // result side: check words, random stalls, one long hold-off
  initial begin : rx_side
    int hold_left;
    bit held;
    mouse_cmd_t got;
    hold_left = 0;
    held = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got.op_code = out_if.op_code;
        got.action  = out_if.action;
        got.delta_x = out_if.delta_x;
        got.delta_y = out_if.delta_y;
        board.check_word(got);
      end
      if (!held && sent >= HoldAtByte) begin
        held = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  // run limit
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    sent = 0;
    in_if.valid = 1'b0;
    in_if.rx_byte = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // move with largest digit bytes and x negative, y from zero bytes, then a reissue
    send_seq('{amd_pkg::CH_CLEAR, amd_pkg::CH_ZERO + 8'd1, amd_pkg::CH_ZERO,
               8'hff, 8'hff, 8'hff, amd_pkg::CH_ONE, 8'h00, 8'h00, 8'h00,
               amd_pkg::CH_END, amd_pkg::CH_END});
    // negative wheel of 999
    send_seq('{amd_pkg::CH_CLEAR, amd_pkg::CH_ZERO + 8'd5, amd_pkg::CH_ONE,
               amd_pkg::CH_ZERO + 8'd9, amd_pkg::CH_ZERO + 8'd9,
               amd_pkg::CH_ZERO + 8'd9, amd_pkg::CH_ZERO, amd_pkg::CH_ZERO,
               amd_pkg::CH_ZERO, amd_pkg::CH_ZERO, amd_pkg::CH_END});
    // overrun: tenth byte dropped, end byte no longer closes the frame
    send_seq('{amd_pkg::CH_ZERO + 8'd7, amd_pkg::CH_END});

    while (sent < ByteTotal) send_frame();
    in_if.valid <= 1'b0;

    // drain outstanding commands, then allow for pipeline latency
    while (board.left() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (board.errors == 0 && board.left() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/amd_pkg.sv
hdl/amd_if.sv
hdl/amd_front.sv
hdl/amd_queue.sv
hdl/amd_back.sv
hdl/ascii_mouse_command_deframer.sv
test/tb.sv
